// ===== rtl/core/cce_pkg.sv =====
// Shared widths, latencies and types for the circle collision rebound pipeline.
// No dependencies; every module of the block imports this package.
package cce_pkg;

	localparam int MS_W = 15;
	localparam logic [MS_W-1:0] MS_RESET = 15'd2560;

	localparam int VEL_W = 16;
	localparam int VN_W = 18;

	localparam int DIV_N_W = 35;
	localparam int DIV_D_W = 18;
	localparam int DIV_Q_W = 17;

	localparam int SQ_W = 36;
	localparam int RT_W = 18;
	localparam int RM_W = RT_W + 3;

	localparam int FRONT_LAT = 4;
	localparam int DIV_LAT = DIV_Q_W;
	localparam int ISQ_LAT = RT_W + 1;
	localparam int LIM_LAT = DIV_LAT + ISQ_LAT + 4;
	localparam int PIPE_LAT = FRONT_LAT + DIV_LAT + 1 + LIM_LAT;

	typedef logic signed [VEL_W-1:0] vel_t;
	typedef logic signed [VN_W-1:0] vn_t;

	typedef struct packed {
		logic coll;
		logic reb;
		vel_t avx;
		vel_t avy;
		vel_t bvx;
		vel_t bvy;
	} side_t;

endpackage

// ===== rtl/core/cce_udiv.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on cce_pkg for operand widths.
module cce_udiv import cce_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic [DIV_Q_W-1:0] quo
);

	logic [DIV_N_W-1:0] rem_s [DIV_Q_W+1];
	logic [DIV_D_W-1:0] den_s [DIV_Q_W+1];
	logic [DIV_Q_W-1:0] quo_s [DIV_Q_W+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < DIV_Q_W; g++) begin : g_stage
		localparam int K = DIV_Q_W - 1 - g;
		logic [DIV_N_W-1:0] dk;
		logic               ge;

		always_comb begin
			dk = DIV_N_W'(den_s[g]) << K;
			ge = rem_s[g] >= dk;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? rem_s[g] - dk : rem_s[g];
				den_s[g+1] <= den_s[g];
				quo_s[g+1] <= quo_s[g] | (DIV_Q_W'(ge) << K);
			end
		end
	end

	assign quo = quo_s[DIV_Q_W];

endmodule

// ===== rtl/core/cce_isqrt.sv =====
// Pipelined ceiling square root, two radicand bits per stage plus a rounding stage.
// Depends on cce_pkg for widths.
module cce_isqrt import cce_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [SQ_W-1:0] rad,
	output logic [RT_W-1:0] root
);

	logic [RM_W-1:0] rem_s  [RT_W+1];
	logic [RT_W-1:0] root_s [RT_W+1];
	logic [SQ_W-1:0] rad_s  [RT_W+1];
	logic [RT_W-1:0] ceil_s;

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;

	for (genvar g = 0; g < RT_W; g++) begin : g_stage
		logic [RM_W-1:0] cur;
		logic [RM_W-1:0] trial;
		logic            ge;

		always_comb begin
			cur   = {rem_s[g][RM_W-3:0], rad_s[g][SQ_W-1:SQ_W-2]};
			trial = RM_W'({root_s[g], 2'b01});
			ge    = cur >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= ge ? cur - trial : cur;
				root_s[g+1] <= {root_s[g][RT_W-2:0], ge};
				rad_s[g+1]  <= rad_s[g] << 2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ceil_s <= root_s[RT_W] + RT_W'(rem_s[RT_W] != '0);
		end
	end

	assign root = ceil_s;

endmodule

// ===== rtl/core/cce_front.sv =====
// Front stages: overlap and approach tests and the rebound dividends and divisor.
// Depends on cce_pkg for widths and the side-band word type.
module cce_front import cce_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [19:0]           rel_x,
	input  logic signed [19:0]           rel_y,
	input  vel_t                         a_vx,
	input  vel_t                         a_vy,
	input  vel_t                         b_vx,
	input  vel_t                         b_vy,
	input  logic [15:0]                  a_mass,
	input  logic [15:0]                  b_mass,
	input  logic [17:0]                  a_radius,
	input  logic [17:0]                  b_radius,
	input  logic                         a_live,
	input  logic                         b_live,
	output side_t                        side,
	output logic [3:0][DIV_N_W-1:0]      num,
	output logic [DIV_D_W-1:0]           den,
	output logic [3:0]                   neg
);

	logic [18:0]        rs;
	logic signed [16:0] md;
	logic signed [16:0] ams;
	logic signed [16:0] bms;
	logic signed [24:0] dx;
	logic signed [24:0] dy;
	logic [34:0]        an [4];

	logic [39:0]        rxx_s1, ryy_s1;
	logic [37:0]        rss_s1;
	logic signed [24:0] dx_s1, dy_s1;
	logic signed [32:0] p_s1 [4];
	logic signed [32:0] q_s1 [4];
	logic [16:0]        msum_s1;
	logic               ok_s1;
	side_t              v_s1;

	logic [40:0]        d2_s2;
	logic               coll_s2;
	logic [49:0]        dxx_s2, dyy_s2;
	logic signed [34:0] n_s2 [4];
	logic [16:0]        msum_s2;
	side_t              v_s2;

	logic [47:0]        h_s3, e_s3;
	logic [3:0][DIV_N_W-1:0] num_s3;
	logic [DIV_D_W-1:0] den_s3;
	logic [3:0]         neg_s3;
	side_t              v_s3;

	side_t              v_s4;
	logic [3:0][DIV_N_W-1:0] num_s4;
	logic [DIV_D_W-1:0] den_s4;
	logic [3:0]         neg_s4;

	always_comb begin
		rs  = 19'(a_radius) + 19'(b_radius);
		md  = 17'(a_mass) - 17'(b_mass);
		ams = {1'b0, a_mass};
		bms = {1'b0, b_mass};
		dx  = (25'(rel_x) <<< 3) + (25'(rel_x) <<< 1) + 25'(a_vx) - 25'(b_vx);
		dy  = (25'(rel_y) <<< 3) + (25'(rel_y) <<< 1) + 25'(a_vy) - 25'(b_vy);
		for (int i = 0; i < 4; i++) begin
			an[i] = n_s2[i][34] ? 35'(-n_s2[i]) : 35'(n_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rxx_s1  <= rel_x * rel_x;
			ryy_s1  <= rel_y * rel_y;
			rss_s1  <= rs * rs;
			dx_s1   <= dx;
			dy_s1   <= dy;
			p_s1[0] <= a_vx * md;
			p_s1[1] <= a_vy * md;
			p_s1[2] <= b_vx * md;
			p_s1[3] <= b_vy * md;
			q_s1[0] <= bms * b_vx;
			q_s1[1] <= bms * b_vy;
			q_s1[2] <= ams * a_vx;
			q_s1[3] <= ams * a_vy;
			msum_s1 <= 17'(a_mass) + 17'(b_mass);
			ok_s1   <= a_live && b_live && (a_mass != '0) && (b_mass != '0);
			v_s1    <= '{coll: 1'b0, reb: 1'b0, avx: a_vx, avy: a_vy, bvx: b_vx, bvy: b_vy};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s2   <= 41'(rxx_s1) + 41'(ryy_s1);
			coll_s2 <= ok_s1 && ((41'(rxx_s1) + 41'(ryy_s1)) <= 41'(rss_s1));
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			n_s2[0] <= 35'(p_s1[0]) + (35'(q_s1[0]) <<< 1);
			n_s2[1] <= 35'(p_s1[1]) + (35'(q_s1[1]) <<< 1);
			n_s2[2] <= (35'(q_s1[2]) <<< 1) - 35'(p_s1[2]);
			n_s2[3] <= (35'(q_s1[3]) <<< 1) - 35'(p_s1[3]);
			msum_s2 <= msum_s1;
			v_s2    <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s3   <= (48'(d2_s2) << 6) + (48'(d2_s2) << 5) + (48'(d2_s2) << 2);
			e_s3   <= dxx_s2[47:0] + dyy_s2[47:0];
			for (int i = 0; i < 4; i++) begin
				num_s3[i] <= DIV_N_W'({an[i][33:0], 1'b0}) + DIV_N_W'(msum_s2);
				neg_s3[i] <= n_s2[i][34];
			end
			den_s3 <= {msum_s2, 1'b0};
			v_s3   <= '{coll: coll_s2, reb: v_s2.reb, avx: v_s2.avx, avy: v_s2.avy,
				bvx: v_s2.bvx, bvy: v_s2.bvy};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4   <= '{coll: v_s3.coll, reb: v_s3.coll && (h_s3 > e_s3),
				avx: v_s3.avx, avy: v_s3.avy, bvx: v_s3.bvx, bvy: v_s3.bvy};
			num_s4 <= num_s3;
			den_s4 <= den_s3;
			neg_s4 <= neg_s3;
		end
	end

	assign side = v_s4;
	assign num  = num_s4;
	assign den  = den_s4;
	assign neg  = neg_s4;

endmodule

// ===== rtl/core/cce_limit.sv =====
// Speed limiter for one velocity vector: magnitude test, ceiling root and scaling.
// Depends on cce_pkg, cce_isqrt and cce_udiv.
module cce_limit import cce_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [MS_W-1:0] speed_lim,
	input  vn_t             vx,
	input  vn_t             vy,
	output vel_t            ox,
	output vel_t            oy
);

	logic [SQ_W-1:0]   sqx_s1, sqy_s1;
	logic [29:0]       ms2_s1;
	vn_t               vx_s1, vy_s1;

	logic [SQ_W-1:0]   s_s2;
	logic              lim_s2;
	vn_t               vx_s2, vy_s2;

	vn_t               vx_r [ISQ_LAT];
	vn_t               vy_r [ISQ_LAT];
	logic              lim_r [ISQ_LAT];
	logic [RT_W-1:0]   m;

	logic [16:0]       ax, ay;
	logic [31:0]       prx, pry;
	logic [DIV_N_W-1:0] px_s3, py_s3;
	logic [DIV_D_W-1:0] m_s3;
	logic              sx_s3, sy_s3, lim_s3;
	vel_t              vx_s3, vy_s3;

	logic              sx_d [DIV_LAT];
	logic              sy_d [DIV_LAT];
	logic              lim_d [DIV_LAT];
	vel_t              vx_d [DIV_LAT];
	vel_t              vy_d [DIV_LAT];
	logic [DIV_Q_W-1:0] qx, qy;

	vel_t              ox_s4, oy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= vx * vx;
			sqy_s1 <= vy * vy;
			ms2_s1 <= speed_lim * speed_lim;
			vx_s1  <= vx;
			vy_s1  <= vy;
			s_s2   <= sqx_s1 + sqy_s1;
			lim_s2 <= (sqx_s1 + sqy_s1) > SQ_W'(ms2_s1);
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
		end
	end

	cce_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (s_s2),
		.root (m)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			vx_r[0]  <= vx_s2;
			vy_r[0]  <= vy_s2;
			lim_r[0] <= lim_s2;
			for (int k = 1; k < ISQ_LAT; k++) begin
				vx_r[k]  <= vx_r[k-1];
				vy_r[k]  <= vy_r[k-1];
				lim_r[k] <= lim_r[k-1];
			end
		end
	end

	always_comb begin
		ax  = vx_r[ISQ_LAT-1][VN_W-1] ? 17'(-vx_r[ISQ_LAT-1]) : 17'(vx_r[ISQ_LAT-1]);
		ay  = vy_r[ISQ_LAT-1][VN_W-1] ? 17'(-vy_r[ISQ_LAT-1]) : 17'(vy_r[ISQ_LAT-1]);
		prx = ax * speed_lim;
		pry = ay * speed_lim;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3  <= DIV_N_W'(prx);
			py_s3  <= DIV_N_W'(pry);
			m_s3   <= DIV_D_W'(m);
			sx_s3  <= vx_r[ISQ_LAT-1][VN_W-1];
			sy_s3  <= vy_r[ISQ_LAT-1][VN_W-1];
			lim_s3 <= lim_r[ISQ_LAT-1];
			vx_s3  <= VEL_W'(vx_r[ISQ_LAT-1]);
			vy_s3  <= VEL_W'(vy_r[ISQ_LAT-1]);
		end
	end

	cce_udiv u_divx (
		.clk (clk),
		.en  (en),
		.num (px_s3),
		.den (m_s3),
		.quo (qx)
	);

	cce_udiv u_divy (
		.clk (clk),
		.en  (en),
		.num (py_s3),
		.den (m_s3),
		.quo (qy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sx_d[0]  <= sx_s3;
			sy_d[0]  <= sy_s3;
			lim_d[0] <= lim_s3;
			vx_d[0]  <= vx_s3;
			vy_d[0]  <= vy_s3;
			for (int k = 1; k < DIV_LAT; k++) begin
				sx_d[k]  <= sx_d[k-1];
				sy_d[k]  <= sy_d[k-1];
				lim_d[k] <= lim_d[k-1];
				vx_d[k]  <= vx_d[k-1];
				vy_d[k]  <= vy_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (lim_d[DIV_LAT-1]) begin
				ox_s4 <= sx_d[DIV_LAT-1] ? -VEL_W'(qx) : VEL_W'(qx);
				oy_s4 <= sy_d[DIV_LAT-1] ? -VEL_W'(qy) : VEL_W'(qy);
			end else begin
				ox_s4 <= vx_d[DIV_LAT-1];
				oy_s4 <= vy_d[DIV_LAT-1];
			end
		end
	end

	assign ox = ox_s4;
	assign oy = oy_s4;

endmodule

// ===== rtl/core/circle_collision_elastic_rebound.sv =====
// Throughput: one word per cycle while in_stall is low; the pipeline and the limiter's
// root and divider stages each take a new word every enabled cycle, and a skid register
// holds one result word while the output stalls; in_stall is high while it is full.
// Reset clears all valid bits and loads the speed limit with 2560; payload is not reset.
// Depends on cce_pkg, cce_front, cce_udiv and cce_limit.
module circle_collision_elastic_rebound import cce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [MS_W-1:0]    cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [19:0] rel_x,
	input  logic signed [19:0] rel_y,
	input  vel_t               a_vx,
	input  vel_t               a_vy,
	input  vel_t               b_vx,
	input  vel_t               b_vy,
	input  logic [15:0]        a_mass,
	input  logic [15:0]        b_mass,
	input  logic [17:0]        a_radius,
	input  logic [17:0]        b_radius,
	input  logic               a_live,
	input  logic               b_live,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               collided,
	output logic               rebounded,
	output vel_t               new_a_vx,
	output vel_t               new_a_vy,
	output vel_t               new_b_vx,
	output vel_t               new_b_vy
);

	localparam int SD_N = DIV_LAT + 1 + LIM_LAT;

	logic [MS_W-1:0]         speed_lim_q;
	logic                    en;
	logic [PIPE_LAT-1:0]     v_q;

	side_t                   side_f;
	logic [3:0][DIV_N_W-1:0] num_f;
	logic [DIV_D_W-1:0]      den_f;
	logic [3:0]              neg_f;
	logic [DIV_Q_W-1:0]      quo [4];

	side_t                   sd_s [SD_N];
	logic [3:0]              nd_s [DIV_LAT];
	vn_t                     vs_s [4];
	vel_t                    lv [4];

	side_t                   res;
	side_t                   out_q, skid_q;
	logic                    out_v_q, skid_v_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_lim_q <= MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			speed_lim_q <= cfg_data;
		end
	end

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[PIPE_LAT-2:0], in_valid};
		end
	end

	cce_front u_front (
		.clk      (clk),
		.en       (en),
		.rel_x    (rel_x),
		.rel_y    (rel_y),
		.a_vx     (a_vx),
		.a_vy     (a_vy),
		.b_vx     (b_vx),
		.b_vy     (b_vy),
		.a_mass   (a_mass),
		.b_mass   (b_mass),
		.a_radius (a_radius),
		.b_radius (b_radius),
		.a_live   (a_live),
		.b_live   (b_live),
		.side     (side_f),
		.num      (num_f),
		.den      (den_f),
		.neg      (neg_f)
	);

	for (genvar i = 0; i < 4; i++) begin : g_div
		cce_udiv u_div (
			.clk (clk),
			.en  (en),
			.num (num_f[i]),
			.den (den_f),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_f;
			nd_s[0] <= neg_f;
			for (int k = 1; k < SD_N; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
			for (int k = 1; k < DIV_LAT; k++) begin
				nd_s[k] <= nd_s[k-1];
			end
			for (int i = 0; i < 4; i++) begin
				vs_s[i] <= nd_s[DIV_LAT-1][i] ? -VN_W'(quo[i]) : VN_W'(quo[i]);
			end
		end
	end

	cce_limit u_lim_a (
		.clk       (clk),
		.en        (en),
		.speed_lim (speed_lim_q),
		.vx        (vs_s[0]),
		.vy        (vs_s[1]),
		.ox        (lv[0]),
		.oy        (lv[1])
	);

	cce_limit u_lim_b (
		.clk       (clk),
		.en        (en),
		.speed_lim (speed_lim_q),
		.vx        (vs_s[2]),
		.vy        (vs_s[3]),
		.ox        (lv[2]),
		.oy        (lv[3])
	);

	always_comb begin
		res = sd_s[SD_N-1];
		if (res.reb) begin
			res.avx = lv[0];
			res.avy = lv[1];
			res.bvx = lv[2];
			res.bvy = lv[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			out_v_q  <= skid_v_q || v_q[PIPE_LAT-1];
			skid_v_q <= 1'b0;
		end else if (en && v_q[PIPE_LAT-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (en) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign collided  = out_q.coll;
	assign rebounded = out_q.reb;
	assign new_a_vx  = out_q.avx;
	assign new_a_vy  = out_q.avy;
	assign new_b_vx  = out_q.bvx;
	assign new_b_vy  = out_q.bvy;

	a_skid_needs_held_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall))
		else $error("Skid register filled while the output register was free.");

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid register holds a word while the output register is empty.");

	a_reb_implies_coll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!rebounded || collided))
		else $error("Rebound reported without a collision.");

endmodule
